// File: rtl/kvs_pkg.sv
// shared types and constants of the keyframe vector sampler
package kvs_pkg;
  localparam int MaxKeys = 16;
  localparam int IdxW = $clog2(MaxKeys);
  localparam int CntW = 5;
  localparam int AddrW = 1;
  localparam logic [AddrW-1:0] RegKeyCount = 1'b0;
  localparam logic ActLoad = 1'b0;
  localparam logic ActSample = 1'b1;

  // controller to datapath
  typedef struct packed {
    logic            load;
    logic            capture;
    logic            rd_en;
    logic [IdxW-1:0] rd_idx;
    logic            first_chk;
    logic            seg_chk;
    logic            div_start;
    logic            mul_start;
    logic [1:0]      mul_lane;
    logic            out_load;
    logic [1:0]      out_sel;
  } kvs_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic hit;
    logic div_done;
    logic mul_done;
  } kvs_sts_t;

  localparam logic [1:0] SelFirst = 2'd0;
  localparam logic [1:0] SelBlend = 2'd1;
  localparam logic [1:0] SelLast  = 2'd2;
endpackage

// File: rtl/kvs_if.sv
// valid/ready channel interfaces for items in and out
interface kvs_in_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [3:0]  key_index;
  logic [31:0] key_time;
  logic signed [31:0] key_x;
  logic signed [31:0] key_y;
  logic signed [31:0] key_z;
  logic [31:0] query_time;
  modport source (output valid, action, key_index, key_time, key_x, key_y, key_z,
                  query_time, input ready);
  modport sink (input valid, action, key_index, key_time, key_x, key_y, key_z,
                query_time, output ready);
endinterface

interface kvs_out_if;
  logic valid;
  logic ready;
  logic signed [31:0] out_x;
  logic signed [31:0] out_y;
  logic signed [31:0] out_z;
  modport source (output valid, out_x, out_y, out_z, input ready);
  modport sink (input valid, out_x, out_y, out_z, output ready);
endinterface

// File: rtl/kvs_ctrl.sv
// controller state machine: segment search and arithmetic sequencing
module kvs_ctrl import kvs_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic            in_action_i,
  input  logic [CntW-1:0] key_count_i,
  input  logic            out_busy_i,
  input  kvs_sts_t        sts_i,
  output logic            in_ready_o,
  output kvs_cmd_t        cmd_o
);
  typedef enum logic [3:0] {
    S_IDLE, S_RD0, S_FIRST, S_RDSEG, S_SEG, S_DIV, S_MUL, S_MULW, S_RDLAST, S_OUT
  } state_e;

  state_e          state_q;
  logic [IdxW-1:0] seg_q;
  logic [1:0]      lane_q;
  logic [1:0]      sel_q;
  logic [IdxW-1:0] last_idx;
  logic            single;

  // clamp key count into 1..MaxKeys
  always_comb begin
    if (key_count_i == '0 || key_count_i == CntW'(1)) begin
      last_idx = '0;
    end else if (key_count_i > CntW'(MaxKeys)) begin
      last_idx = IdxW'(MaxKeys - 1);
    end else begin
      last_idx = IdxW'(key_count_i - CntW'(1));
    end
    single = (last_idx == '0);
  end

  assign in_ready_o = (state_q == S_IDLE) && !out_busy_i;

  // command decode
  always_comb begin
    cmd_o = '0;
    cmd_o.load      = (state_q == S_IDLE) && in_valid_i && !out_busy_i &&
                      (in_action_i == ActLoad);
    cmd_o.capture   = (state_q == S_IDLE) && in_valid_i && !out_busy_i;
    cmd_o.rd_en     = (state_q == S_RD0) || (state_q == S_RDSEG) || (state_q == S_RDLAST);
    cmd_o.rd_idx    = (state_q == S_RDLAST) ? last_idx : seg_q;
    cmd_o.first_chk = (state_q == S_FIRST);
    cmd_o.seg_chk   = (state_q == S_SEG);
    cmd_o.div_start = (state_q == S_SEG) && sts_i.hit;
    cmd_o.mul_start = (state_q == S_MUL);
    cmd_o.mul_lane  = lane_q;
    cmd_o.out_load  = (state_q == S_OUT);
    cmd_o.out_sel   = sel_q;
  end

  // state and registered control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      seg_q   <= '0;
      lane_q  <= '0;
      sel_q   <= SelFirst;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (in_valid_i && !out_busy_i && in_action_i == ActSample) begin
            seg_q   <= '0;
            state_q <= S_RD0;
          end
        end
        S_RD0: state_q <= S_FIRST;
        S_FIRST: begin
          if (single || sts_i.hit) begin
            sel_q   <= SelFirst;
            state_q <= S_OUT;
          end else begin
            state_q <= S_RDSEG;
          end
        end
        S_RDSEG: state_q <= S_SEG;
        S_SEG: begin
          if (sts_i.hit) begin
            state_q <= S_DIV;
          end else if (seg_q + IdxW'(1) >= last_idx) begin
            state_q <= S_RDLAST;
          end else begin
            seg_q   <= seg_q + IdxW'(1);
            state_q <= S_RDSEG;
          end
        end
        S_DIV: begin
          if (sts_i.div_done) begin
            lane_q  <= '0;
            state_q <= S_MUL;
          end
        end
        S_MUL: state_q <= S_MULW;
        S_MULW: begin
          if (sts_i.mul_done) begin
            if (lane_q == 2'd2) begin
              sel_q   <= SelBlend;
              state_q <= S_OUT;
            end else begin
              lane_q  <= lane_q + 2'd1;
              state_q <= S_MUL;
            end
          end
        end
        S_RDLAST: begin
          sel_q   <= SelLast;
          state_q <= S_OUT;
        end
        S_OUT: state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end
endmodule

// File: rtl/kvs_dp.sv
// datapath: key table, restoring divider, blend multiplier, result register
module kvs_dp import kvs_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  kvs_cmd_t           cmd_i,
  input  logic [3:0]         key_index_i,
  input  logic [31:0]        key_time_i,
  input  logic signed [31:0] key_x_i,
  input  logic signed [31:0] key_y_i,
  input  logic signed [31:0] key_z_i,
  input  logic [31:0]        query_time_i,
  input  logic               out_ready_i,
  output logic               out_valid_o,
  output logic signed [31:0] out_x_o,
  output logic signed [31:0] out_y_o,
  output logic signed [31:0] out_z_o,
  output kvs_sts_t           sts_o
);
  logic [127:0]    mem_lo [MaxKeys];
  logic [127:0]    mem_hi [MaxKeys];
  logic [127:0]    lo_q, hi_q;
  logic [31:0]     query_q;
  logic [47:0]     num_q;
  logic [32:0]     rem_q;
  logic [31:0]     span_q;
  logic [16:0]     w_q;
  logic [5:0]      dcnt_q;
  logic            dbusy_q, ddone_q;
  logic            mdone_q;
  logic signed [63:0] prod_q;
  logic signed [31:0] bx_q, by_q, bz_q;
  logic            valid_q;
  logic [32:0]     rem_sh;
  logic signed [32:0] diff;
  logic signed [31:0] a_sel, b_sel;
  logic signed [31:0] blend_res;
  logic            in_seg;

  // key table, two copies so a segment's ends are read at once
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mem_lo[key_index_i] <= {key_time_i, key_x_i, key_y_i, key_z_i};
      if (key_index_i != '0) begin
        mem_hi[key_index_i - 4'd1] <= {key_time_i, key_x_i, key_y_i, key_z_i};
      end
    end
    if (cmd_i.rd_en) begin
      lo_q <= mem_lo[cmd_i.rd_idx];
      hi_q <= mem_hi[cmd_i.rd_idx];
    end
    if (cmd_i.capture) query_q <= query_time_i;
  end

  // segment tests
  assign in_seg = (query_q >= lo_q[127:96]) && (query_q <= hi_q[127:96]);
  assign sts_o = '{
    hit:      cmd_i.first_chk ? (query_q <= lo_q[127:96]) : (cmd_i.seg_chk && in_seg),
    div_done: ddone_q,
    mul_done: mdone_q
  };

  // restoring divider for the weight, one quotient bit a cycle
  assign rem_sh = {rem_q[31:0], num_q[47]};
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dbusy_q <= 1'b0;
      ddone_q <= 1'b0;
      dcnt_q  <= '0;
    end else begin
      ddone_q <= 1'b0;
      if (cmd_i.div_start) begin
        dbusy_q <= (hi_q[127:96] != lo_q[127:96]);
        ddone_q <= (hi_q[127:96] == lo_q[127:96]);
        dcnt_q  <= 6'd48;
      end else if (dbusy_q) begin
        dcnt_q <= dcnt_q - 6'd1;
        if (dcnt_q == 6'd1) begin
          dbusy_q <= 1'b0;
          ddone_q <= 1'b1;
        end
      end
    end
  end
  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      num_q  <= {query_q - lo_q[127:96], 16'd0};
      rem_q  <= '0;
      span_q <= hi_q[127:96] - lo_q[127:96];
      w_q    <= '0;
    end else if (dbusy_q) begin
      num_q <= {num_q[46:0], 1'b0};
      if (rem_sh >= {1'b0, span_q}) begin
        rem_q <= rem_sh - {1'b0, span_q};
        w_q   <= {w_q[15:0], 1'b1};
      end else begin
        rem_q <= rem_sh;
        w_q   <= {w_q[15:0], 1'b0};
      end
    end
  end

  // blend: one lane a pass, multiply then floor-shift and add
  always_comb begin
    case (cmd_i.mul_lane)
      2'd0:    begin a_sel = lo_q[95:64]; b_sel = hi_q[95:64]; end
      2'd1:    begin a_sel = lo_q[63:32]; b_sel = hi_q[63:32]; end
      default: begin a_sel = lo_q[31:0];  b_sel = hi_q[31:0];  end
    endcase
    diff = 33'(b_sel) - 33'(a_sel);
    blend_res = 32'(64'(a_sel) + (prod_q >>> 16));
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) mdone_q <= 1'b0;
    else mdone_q <= cmd_i.mul_start;
  end
  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_start) prod_q <= 64'(diff * $signed({1'b0, w_q}));
    if (mdone_q) begin
      case (cmd_i.mul_lane)
        2'd0:    bx_q <= blend_res;
        2'd1:    by_q <= blend_res;
        default: bz_q <= blend_res;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) valid_q <= 1'b0;
    else if (cmd_i.out_load) valid_q <= 1'b1;
    else if (out_ready_i) valid_q <= 1'b0;
  end
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      case (cmd_i.out_sel)
        SelBlend: begin out_x_o <= bx_q; out_y_o <= by_q; out_z_o <= bz_q; end
        default: begin
          out_x_o <= lo_q[95:64]; out_y_o <= lo_q[63:32]; out_z_o <= lo_q[31:0];
        end
      endcase
    end
  end
  assign out_valid_o = valid_q;
endmodule

// File: rtl/keyframe_vector_sampler.sv
// Keyframe vector sampler: a load item writes one of 16 keyframes and
// gives no result. A sample item returns the first key when the query lies
// at or before the first key or one key is in use; otherwise the segments are
// read and tested in turn, and a hit runs a 48-step bit-serial divide for
// the weight (skipped when the segment has zero length) and three multiply
// passes. The worst case, a hit in the fifteenth segment, spends most of its
// time in the divider. The result waits in an output register; a new item is
// taken once it has been accepted.
module keyframe_vector_sampler import kvs_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  kvs_in_if.sink      in_if,
  kvs_out_if.source   out_if,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  logic [CntW-1:0] key_count_q;
  kvs_cmd_t        cmd;
  kvs_sts_t        sts;

  // configuration register
  assign pready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) key_count_q <= CntW'(1);
    else if (psel && penable && pwrite && paddr[2 +: AddrW] == RegKeyCount &&
             paddr[1:0] == 2'b00)
      key_count_q <= pwdata[CntW-1:0];
  end
  assign prdata = (paddr[2 +: AddrW] == RegKeyCount) ? 32'(key_count_q) : '0;

  kvs_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(in_if.valid), .in_action_i(in_if.action),
    .key_count_i(key_count_q), .out_busy_i(out_if.valid),
    .sts_i(sts), .in_ready_o(in_if.ready), .cmd_o(cmd)
  );

  kvs_dp u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd),
    .key_index_i(in_if.key_index), .key_time_i(in_if.key_time),
    .key_x_i(in_if.key_x), .key_y_i(in_if.key_y), .key_z_i(in_if.key_z),
    .query_time_i(in_if.query_time), .out_ready_i(out_if.ready),
    .out_valid_o(out_if.valid), .out_x_o(out_if.out_x),
    .out_y_o(out_if.out_y), .out_z_o(out_if.out_z), .sts_o(sts)
  );
endmodule

// File: rtl/kvs_checker.sv
// port-level assertions of the sampler, bound to the top level
module kvs_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_i,
  input logic in_action_i,
  input logic out_valid_i,
  input logic out_ready_i
);
  // no item is taken while a result waits
  a_no_take_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> !in_ready_i) else $error("item taken while result waits");
  // a load item gives no result next cycle
  a_load_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i && !in_action_i && !out_valid_i) |=> !out_valid_i)
    else $error("load item gave a result");
  // a sample item keeps the block busy next cycle
  a_sample_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i && in_action_i) |=> !in_ready_i)
    else $error("sample item did not hold the input");
  // a result stays until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> out_valid_i) else $error("result dropped");
endmodule

bind keyframe_vector_sampler kvs_checker u_kvs_checker (
  .clk_i(clk_i), .rst_ni(rst_ni),
  .in_valid_i(in_if.valid), .in_ready_i(in_if.ready), .in_action_i(in_if.action),
  .out_valid_i(out_if.valid), .out_ready_i(out_if.ready)
);
